// ===== hw/rtl/tpsd_pkg.sv =====
// Shared types, constants and pixel packing for the TGA pixel stream decoder.
package tpsd_pkg;

    localparam int MAX_RUN  = 128;
    localparam int Q_DEPTH  = 4;
    localparam int Q_AW     = $clog2(Q_DEPTH);
    localparam int Q_CW     = $clog2(Q_DEPTH + 1);

    typedef enum logic [2:0] {
        CFG_IMAGE_KIND      = 3'd0,
        CFG_BYTES_PER_PIXEL = 3'd1,
        CFG_IMAGE_WIDTH     = 3'd2,
        CFG_IMAGE_HEIGHT    = 3'd3,
        CFG_IDENT_LENGTH    = 3'd4,
        CFG_PALETTE_ENTRIES = 3'd5
    } t_cfg_idx;

    typedef enum logic [2:0] {
        PH_SKIP    = 3'd0,
        PH_PALETTE = 3'd1,
        PH_HEADER  = 3'd2,
        PH_PIXEL   = 3'd3,
        PH_DONE    = 3'd4
    } t_phase;

    // Configuration plus values derived from it, registered in the top level.
    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  bpp;        // effective bytes per pixel, 1..4
        logic [15:0] width;
        logic [15:0] height;
        logic [7:0]  ident;
        logic [15:0] pal_entries;
        logic [31:0] total;      // width * height
        logic [17:0] pal_bytes;  // pal_entries * bpp
    } t_cfg;

    // One decoded pixel group travelling from front to back.
    typedef struct packed {
        logic [31:0] value;      // {comp3, comp2, comp1, comp0}
        logic [7:0]  count;
        logic        done;
        logic        fault;
        logic        restart;    // first group of a new image
    } t_pix;

    // Place file-order bytes into components; three or more bytes swap BGR to RGB.
    function automatic logic [31:0] pack_pixel(input logic [23:0] pa, input logic [7:0] last,
                                               input logic [2:0] bpp);
        logic [31:0] v;
        v = '0;
        unique case (bpp)
            3'd1: v = {24'd0, last};
            3'd2: v = {16'd0, last, pa[7:0]};
            3'd3: v = {8'd0, pa[7:0], pa[15:8], last};
            3'd4: v = {last, pa[7:0], pa[15:8], pa[23:16]};
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== hw/rtl/tpsd_if.sv =====
// Stream and configuration channel interfaces of the TGA pixel stream decoder.
interface tpsd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       new_image;
    modport source (output valid, output data_byte, output new_image, input ready);
    modport sink   (input valid, input data_byte, input new_image, output ready);
endinterface

interface tpsd_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  comp0;
    logic [7:0]  comp1;
    logic [7:0]  comp2;
    logic [7:0]  comp3;
    logic [7:0]  repeat_count;
    logic [15:0] dest_column;
    logic [15:0] dest_row;
    logic        image_done;
    logic        index_fault;
    modport source (output valid, output comp0, output comp1, output comp2, output comp3,
                    output repeat_count, output dest_column, output dest_row,
                    output image_done, output index_fault, input ready);
    modport sink   (input valid, input comp0, input comp1, input comp2, input comp3,
                    input repeat_count, input dest_column, input dest_row,
                    input image_done, input index_fault, output ready);
endinterface

interface tpsd_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/tpsd_front.sv =====
// Byte parser: ident skip, palette load, packet headers, pixel assembly and clipping.
module tpsd_front #(
    parameter int PALETTE_DEPTH = 256
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tpsd_pkg::t_cfg i_cfg,
    input  logic           i_hold,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [7:0]     i_data,
    input  logic           i_new,
    output logic           o_push,
    output tpsd_pkg::t_pix o_item,
    input  logic           i_q_full
);
    import tpsd_pkg::*;

    localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam logic [15:0] DEPTH16 = 16'(PALETTE_DEPTH);

    logic [31:0] r_mem [PALETTE_DEPTH];
    logic [31:0] r_mem_q;

    t_phase      r_phase, n_phase;
    logic [17:0] r_bc, n_bc;
    logic [15:0] r_entry, n_entry;
    logic [7:0]  r_prem, n_prem;
    logic        r_prun, n_prun;
    logic [23:0] r_pa, n_pa;
    logic [1:0]  r_pbi, n_pbi;
    logic [31:0] r_pd, n_pd;
    logic        r_fresh, n_fresh;

    // effective state after restart and phase skipping
    t_phase      e_ph;
    logic [17:0] e_bc;
    logic [15:0] e_entry;
    logic [7:0]  e_prem;
    logic        e_prun;
    logic [23:0] e_pa;
    logic [1:0]  e_pbi;
    logic [31:0] e_pd;
    logic        e_fresh;
    logic        last;

    // per-byte outputs
    logic        wr_en, rd_en, has_res, use_mem, fault, done, px_ok;
    logic [31:0] value, wr_data, pd_sum, left;
    logic [7:0]  cnt;

    // stage after the palette read
    logic        r_b_valid;
    t_pix        r_b;
    logic        r_b_mem;

    logic accept;

    assign o_ready = !i_hold && (!r_b_valid || !i_q_full);
    assign accept  = i_valid && o_ready;

    // Apply restart, then pass over phases with nothing left to consume.
    always_comb begin
        e_ph = r_phase; e_bc = r_bc; e_entry = r_entry; e_prem = r_prem; e_prun = r_prun;
        e_pa = r_pa; e_pbi = r_pbi; e_pd = r_pd; e_fresh = r_fresh;
        if (i_new) begin
            e_ph = PH_SKIP; e_bc = '0; e_entry = '0; e_prem = '0; e_prun = 1'b0;
            e_pa = '0; e_pbi = '0; e_pd = '0; e_fresh = 1'b1;
        end
        if (e_ph == PH_SKIP && e_bc >= {10'd0, i_cfg.ident}) begin
            e_ph = PH_PALETTE; e_bc = '0; e_pbi = '0; e_pa = '0; e_entry = '0;
        end
        if (e_ph == PH_PALETTE && e_bc >= i_cfg.pal_bytes) begin
            e_ph = i_cfg.kind[0] ? PH_HEADER : PH_PIXEL;
            e_bc = '0; e_pbi = '0; e_pa = '0;
        end
        if ((e_ph == PH_HEADER || e_ph == PH_PIXEL) && e_pd >= i_cfg.total) begin
            e_ph = PH_DONE;
        end
        last = ({1'b0, e_pbi} + 3'd1) >= i_cfg.bpp;
    end

    // Outputs of this byte: palette access and result group.
    always_comb begin
        wr_en = 1'b0; rd_en = 1'b0; has_res = 1'b0; use_mem = 1'b0; fault = 1'b0;
        px_ok = 1'b0; done = 1'b0; value = '0; cnt = 8'd0; pd_sum = e_pd; left = '0;
        wr_data = pack_pixel(e_pa, i_data, i_cfg.bpp);
        unique case (e_ph)
            PH_PALETTE: begin
                wr_en = last && (e_entry < DEPTH16);
            end
            PH_PIXEL: begin
                if (i_cfg.kind[1]) begin
                    px_ok   = 1'b1;
                    use_mem = 1'b1;
                    fault   = ({1'b0, i_data} >= 9'(PALETTE_DEPTH))
                              || ({8'd0, i_data} >= i_cfg.pal_entries);
                    rd_en   = !fault;
                end else if (last) begin
                    px_ok = 1'b1;
                    value = wr_data;
                end
                if (px_ok) begin
                    cnt = (i_cfg.kind[0] && e_prun) ? e_prem : 8'd1;
                    if (cnt == 8'd0) cnt = 8'd1;
                    if (cnt > 8'(MAX_RUN)) cnt = 8'(MAX_RUN);
                    left = i_cfg.total - e_pd;
                    if ({24'd0, cnt} > left) cnt = left[7:0];
                    pd_sum  = e_pd + {24'd0, cnt};
                    done    = pd_sum >= i_cfg.total;
                    has_res = 1'b1;
                end
            end
            PH_SKIP, PH_HEADER, PH_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // Next state of the parser.
    always_comb begin
        n_phase = e_ph; n_bc = e_bc; n_entry = e_entry; n_prem = e_prem; n_prun = e_prun;
        n_pa = e_pa; n_pbi = e_pbi; n_pd = e_pd; n_fresh = e_fresh;
        unique case (e_ph)
            PH_SKIP: n_bc = e_bc + 18'd1;
            PH_PALETTE: begin
                n_bc = e_bc + 18'd1;
                if (!last) begin
                    unique case (e_pbi)
                        2'd0: n_pa[7:0]   = e_pa[7:0]   | i_data;
                        2'd1: n_pa[15:8]  = e_pa[15:8]  | i_data;
                        2'd2: n_pa[23:16] = e_pa[23:16] | i_data;
                        default: n_pa = e_pa;
                    endcase
                    n_pbi = e_pbi + 2'd1;
                end else begin
                    n_pa = '0; n_pbi = '0; n_entry = e_entry + 16'd1;
                end
            end
            PH_HEADER: begin
                n_prun  = i_data[7];
                n_prem  = {1'b0, i_data[6:0]} + 8'd1;
                n_phase = PH_PIXEL;
            end
            PH_PIXEL: begin
                if (!i_cfg.kind[1]) begin
                    if (!last) begin
                        unique case (e_pbi)
                            2'd0: n_pa[7:0]   = e_pa[7:0]   | i_data;
                            2'd1: n_pa[15:8]  = e_pa[15:8]  | i_data;
                            2'd2: n_pa[23:16] = e_pa[23:16] | i_data;
                            default: n_pa = e_pa;
                        endcase
                        n_pbi = e_pbi + 2'd1;
                    end else begin
                        n_pa = '0; n_pbi = '0;
                    end
                end
                if (has_res) begin
                    n_pd    = pd_sum;
                    n_fresh = 1'b0;
                    if (i_cfg.kind[0]) begin
                        if (e_prun || e_prem <= 8'd1) begin
                            n_prem = '0; n_phase = PH_HEADER;
                        end else begin
                            n_prem = e_prem - 8'd1;
                        end
                    end
                    if (done) n_phase = PH_DONE;
                end
            end
            PH_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // Advance parser state on each byte transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SKIP; r_bc <= '0; r_entry <= '0; r_prem <= '0; r_prun <= 1'b0;
            r_pa <= '0; r_pbi <= '0; r_pd <= '0; r_fresh <= 1'b1;
        end else if (accept) begin
            r_phase <= n_phase; r_bc <= n_bc; r_entry <= n_entry; r_prem <= n_prem;
            r_prun <= n_prun; r_pa <= n_pa; r_pbi <= n_pbi; r_pd <= n_pd; r_fresh <= n_fresh;
        end
    end

    // Palette store: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (accept && wr_en) r_mem[e_entry[AW-1:0]] <= wr_data;
        if (accept && rd_en) r_mem_q <= r_mem[i_data[AW-1:0]];
    end

    // Register the group while the palette read completes; hold it while the queue is full.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (accept) begin
            r_b_valid <= has_res;
        end else if (!i_q_full) begin
            r_b_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b.value   <= value;
            r_b.count   <= cnt;
            r_b.done    <= done;
            r_b.fault   <= fault;
            r_b.restart <= e_fresh;
            r_b_mem     <= use_mem && !fault;
        end
    end

    assign o_push = r_b_valid && !i_q_full;
    always_comb begin
        o_item = r_b;
        if (r_b_mem) o_item.value = r_mem_q;
    end

endmodule

// ===== hw/rtl/tpsd_queue.sv =====
// Short queue of decoded pixel groups between parser and position tracker.
module tpsd_queue (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  tpsd_pkg::t_pix            i_item,
    output logic                      o_full,
    input  logic                      i_pop,
    output tpsd_pkg::t_pix            o_item,
    output logic                      o_valid,
    output logic [tpsd_pkg::Q_CW-1:0] o_count
);
    import tpsd_pkg::*;

    t_pix            r_slot [Q_DEPTH];
    logic [Q_AW-1:0] r_wp, r_rp;
    logic [Q_CW-1:0] r_count;

    assign o_full  = r_count == Q_CW'(Q_DEPTH);
    assign o_valid = r_count != '0;
    assign o_count = r_count;
    assign o_item  = r_slot[r_rp];

    // Store on push.
    always_ff @(posedge i_clk) begin
        if (i_push) r_slot[r_wp] <= i_item;
    end

    // Advance pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_count <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + Q_AW'(1);
            if (i_pop)  r_rp <= r_rp + Q_AW'(1);
            if (i_push && !i_pop)      r_count <= r_count + Q_CW'(1);
            else if (i_pop && !i_push) r_count <= r_count - Q_CW'(1);
        end
    end

endmodule

// ===== hw/rtl/tpsd_back.sv =====
// Position tracker: column and row of each group, and the output register.
module tpsd_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tpsd_pkg::t_cfg i_cfg,
    input  logic           i_q_valid,
    input  tpsd_pkg::t_pix i_item,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output tpsd_pkg::t_pix o_item,
    output logic [15:0]    o_col,
    output logic [15:0]    o_row
);
    import tpsd_pkg::*;

    logic        r_valid;
    t_pix        r_item;
    logic [15:0] r_ocol, r_orow;
    logic [15:0] r_col, r_row;
    logic        r_adj;

    logic [15:0] col_b, row_b, adj_col;
    logic [16:0] sum, sum_w;

    assign o_pop = i_q_valid && !r_adj && (!r_valid || i_ready);

    // Base position of the head group and its end column.
    always_comb begin
        col_b   = i_item.restart ? 16'd0 : r_col;
        row_b   = i_item.restart ? (i_cfg.height - 16'd1) : r_row;
        sum     = {1'b0, col_b} + {9'd0, i_item.count};
        sum_w   = sum - {1'b0, i_cfg.width};
        adj_col = r_col - i_cfg.width;
    end

    // Wrap the column, one row per cycle after the first; stop at the image end.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0; r_row <= '0; r_adj <= 1'b0;
        end else if (r_adj) begin
            r_col <= adj_col;
            r_row <= r_row - 16'd1;
            r_adj <= adj_col >= i_cfg.width;
        end else if (o_pop) begin
            if (sum >= {1'b0, i_cfg.width}) begin
                r_col <= sum_w[15:0];
                r_row <= row_b - 16'd1;
                r_adj <= !i_item.done && (sum_w[15:0] >= i_cfg.width);
            end else begin
                r_col <= sum[15:0];
                r_row <= row_b;
                r_adj <= 1'b0;
            end
        end
    end

    // Output register: hold while the receiver stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_item;
            r_ocol <= col_b;
            r_orow <= row_b;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;
    assign o_col   = r_ocol;
    assign o_row   = r_orow;

endmodule

// ===== hw/rtl/tga_pixel_stream_decoder_top.sv =====
// Top level of the TGA pixel stream decoder: configuration, parser, queue, tracker.
//
// Feed the bytes that follow the 18-byte TGA header on i_in, one per transfer;
// set new_image on the first byte of each image. Write the six registers on
// i_cfg (index 0 kind, 1 bytes per pixel, 2 width, 3 height, 4 ident length,
// 5 palette entries) while the block is idle; i_in.ready stays low while a
// write is offered and in the cycle after it.
// o_out carries one pixel group per transfer: components,
// repeat count, destination column and bottom-up row, done and fault flags.
// Throughput is one byte per cycle unless a register write or a full queue
// drops i_in.ready. A byte that completes a group passes the palette read
// stage, then the queue, then the output register before o_out.valid rises.
// When the image is narrower than a run, the tracker wraps the column row by
// row and pops no group meanwhile; the four-entry queue absorbs short bursts,
// but a long run over many narrow rows fills it and drops i_in.ready until
// the wrap is done. Reset returns the control and configuration registers to
// their defaults and the parser to the ident phase; the palette store and the
// data registers keep no reset value. A stalled receiver holds the output
// register, then fills the queue, then drops i_in.ready.
module tga_pixel_stream_decoder_top #(
    parameter int PALETTE_DEPTH = 256
) (
    input  logic i_clk,
    input  logic i_rst_n,
    tpsd_in_if.sink    i_in,
    tpsd_cfg_if.sink   i_cfg,
    tpsd_out_if.source o_out
);
    import tpsd_pkg::*;

    logic [1:0]  r_kind;
    logic [2:0]  r_bpp;
    logic [15:0] r_width, r_height, r_pal;
    logic [7:0]  r_ident;
    logic [2:0]  r_bpp_eff;
    logic [31:0] r_total;
    logic [17:0] r_pal_bytes;
    logic        r_settle;
    logic        cfg_wr;
    logic [2:0]  bpp_eff;

    t_cfg           cfg;
    logic           push, q_full, q_valid, pop, in_ready;
    t_pix           push_item, head, out_item;
    logic [Q_CW-1:0] q_count;
    logic [15:0]    out_col, out_row;

    assign i_cfg.ready = 1'b1;
    assign cfg_wr      = i_cfg.valid;

    // Hold configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= 2'd0; r_bpp <= 3'd4; r_width <= 16'd1; r_height <= 16'd1;
            r_ident <= 8'd0; r_pal <= 16'd0;
        end else if (cfg_wr) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_IMAGE_KIND:      r_kind   <= i_cfg.data[1:0];
                CFG_BYTES_PER_PIXEL: r_bpp    <= i_cfg.data[2:0];
                CFG_IMAGE_WIDTH:     r_width  <= i_cfg.data;
                CFG_IMAGE_HEIGHT:    r_height <= i_cfg.data;
                CFG_IDENT_LENGTH:    r_ident  <= i_cfg.data[7:0];
                CFG_PALETTE_ENTRIES: r_pal    <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    // Clamp the pixel size to one through four.
    assign bpp_eff = (r_bpp == 3'd0) ? 3'd1 : ((r_bpp > 3'd4) ? 3'd4 : r_bpp);

    // Derive pixel size, image size and palette length; block bytes meanwhile.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpp_eff <= 3'd4; r_total <= 32'd1; r_pal_bytes <= '0; r_settle <= 1'b0;
        end else begin
            r_bpp_eff   <= bpp_eff;
            r_total     <= {16'd0, r_width} * {16'd0, r_height};
            r_pal_bytes <= {2'b00, r_pal} * {15'd0, bpp_eff};
            r_settle    <= cfg_wr;
        end
    end

    always_comb begin
        cfg.kind        = r_kind;
        cfg.bpp         = r_bpp_eff;
        cfg.width       = r_width;
        cfg.height      = r_height;
        cfg.ident       = r_ident;
        cfg.pal_entries = r_pal;
        cfg.total       = r_total;
        cfg.pal_bytes   = r_pal_bytes;
    end

    tpsd_front #(.PALETTE_DEPTH(PALETTE_DEPTH)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_hold   (r_settle || cfg_wr),
        .i_valid  (i_in.valid),
        .o_ready  (in_ready),
        .i_data   (i_in.data_byte),
        .i_new    (i_in.new_image),
        .o_push   (push),
        .o_item   (push_item),
        .i_q_full (q_full)
    );

    assign i_in.ready = in_ready;

    tpsd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_item  (head),
        .o_valid (q_valid),
        .o_count (q_count)
    );

    tpsd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_q_valid (q_valid),
        .i_item    (head),
        .o_pop     (pop),
        .o_valid   (o_out.valid),
        .i_ready   (o_out.ready),
        .o_item    (out_item),
        .o_col     (out_col),
        .o_row     (out_row)
    );

    assign o_out.comp0        = out_item.value[7:0];
    assign o_out.comp1        = out_item.value[15:8];
    assign o_out.comp2        = out_item.value[23:16];
    assign o_out.comp3        = out_item.value[31:24];
    assign o_out.repeat_count = out_item.count;
    assign o_out.dest_column  = out_col;
    assign o_out.dest_row     = out_row;
    assign o_out.image_done   = out_item.done;
    assign o_out.index_fault  = out_item.fault;

    // The queue never holds more than its depth.
    assert property (@(posedge i_clk) disable iff (!i_rst_n) q_count <= Q_CW'(Q_DEPTH))
        else $error("pixel queue overflow");

    // No byte is taken in the cycle after a register write.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg.valid && i_cfg.ready) |=> !i_in.ready)
        else $error("byte accepted before configuration settled");

    // Every group covers between one and MAX_RUN pixels.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.repeat_count != 8'd0 && o_out.repeat_count <= 8'(MAX_RUN)))
        else $error("repeat count out of range");

    // A faulted palette index carries no color.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.index_fault) |->
        (o_out.comp0 == 8'd0 && o_out.comp1 == 8'd0 && o_out.comp2 == 8'd0
         && o_out.comp3 == 8'd0))
        else $error("faulted pixel with nonzero components");

endmodule
